// ----- rtl/core/tbwp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Background and window pixel package
// Shared types, constants and the shade color table of the tile renderer.
// ----------------------------------------------------------------------------
package tbwp_pkg;

   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 144;
   localparam int VRAM_BYTES    = 8192;

   localparam logic [8:0] SCREEN_WIDTH_LIM  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] SCREEN_HEIGHT_LIM = 9'(SCREEN_HEIGHT);

   // Tile data occupies the low 6 KiB as 16-bit plane pairs, maps the top 2 KiB.
   localparam int TILE_WORDS = 3072;
   localparam int MAP_BYTES  = 2048;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_RENDER = 2'd1;
   localparam logic [1:0] OP_FRAME  = 2'd2;

   localparam logic [2:0] CSR_LCD_CONTROL = 3'd0;
   localparam logic [2:0] CSR_SCROLL_Y    = 3'd1;
   localparam logic [2:0] CSR_SCROLL_X    = 3'd2;
   localparam logic [2:0] CSR_BG_PALETTE  = 3'd3;
   localparam logic [2:0] CSR_WINDOW_Y    = 3'd4;
   localparam logic [2:0] CSR_WINDOW_X    = 3'd5;

   localparam int LCDC_BG_MAP     = 3;
   localparam int LCDC_TILE_UNSGN = 4;
   localparam int LCDC_WIN_EN     = 5;
   localparam int LCDC_WIN_MAP    = 6;

   typedef struct packed {
      logic [1:0]  op;
      logic [12:0] mem_addr;
      logic [7:0]  mem_data;
      logic [7:0]  line;
      logic [7:0]  pixel_x;
      logic        line_end;
   } req_type;

   typedef struct packed {
      logic        drawn;
      logic [1:0]  shade;
      logic [31:0] argb;
      logic        from_window;
   } rsp_type;

   typedef struct packed {
      logic       draw;
      logic       from_window;
      logic [2:0] row_lo;
      logic [2:0] col_lo;
   } pix_ctl_type;

   function automatic logic [31:0] shade_argb(input logic [1:0] shade);
      logic [31:0] color;
      unique case (shade)
         2'd0: color = 32'hFFE8FCCC;
         2'd1: color = 32'hFFACD490;
         2'd2: color = 32'hFF548C70;
         2'd3: color = 32'hFF142C38;
         default: color = 32'hFFE8FCCC;
      endcase
      return color;
   endfunction

endpackage

// ----- rtl/core/tile_background_window_pixel.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle unless rsp_ready stalls the output; the map
// read, the tile data read and the output register are separate pipeline
// stages, the two reads each on its own memory port.
// Reset clears the pipeline valids, the window state and the configuration
// registers; video memory contents are undefined until written.
// ----------------------------------------------------------------------------
// Background and window pixel renderer
// Stores video memory from write items and renders one background or window
// pixel per render item through a map read, a tile data read and the palette.
// ----------------------------------------------------------------------------
module tile_background_window_pixel
   import tbwp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] lcdc_ff, scy_ff, scx_ff, pal_ff, wy_ff, wx_ff;
   logic       win_active_ff, win_active_in;
   logic [7:0] win_line_ff, win_line_in;

   logic [7:0]  map_mem [MAP_BYTES];
   logic [15:0] tile_mem [TILE_WORDS];

   logic        s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   pix_ctl_type s1_ctl_ff, s1_ctl_in, s2_ctl_ff;
   logic [7:0]  map_rd_ff;
   logic [15:0] tile_rd_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        adv1, adv2, adv3, accept;
   logic        vis_line, vis_px, render, act_now, win_on, use_win;
   logic [7:0]  row, col, win_col;
   logic [10:0] map_idx;
   logic [11:0] tile_idx;
   logic [2:0]  bit_lo;
   logic [1:0]  cnum, shade;
   logic        map_we, tile_we;

   assign adv3      = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;
   assign accept    = req_valid && adv1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcdc_ff <= '0;
         scy_ff  <= '0;
         scx_ff  <= '0;
         pal_ff  <= '0;
         wy_ff   <= '0;
         wx_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LCD_CONTROL: lcdc_ff <= csr_wdata;
            CSR_SCROLL_Y:    scy_ff  <= csr_wdata;
            CSR_SCROLL_X:    scx_ff  <= csr_wdata;
            CSR_BG_PALETTE:  pal_ff  <= csr_wdata;
            CSR_WINDOW_Y:    wy_ff   <= csr_wdata;
            CSR_WINDOW_X:    wx_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      vis_line = {1'b0, req_data.line} < SCREEN_HEIGHT_LIM;
      vis_px   = {1'b0, req_data.pixel_x} < SCREEN_WIDTH_LIM;
      render   = (req_data.op == OP_RENDER) && vis_line;
      act_now  = win_active_ff || (req_data.line == wy_ff);
      win_on   = act_now && lcdc_ff[LCDC_WIN_EN];
      use_win  = win_on && (({1'b0, req_data.pixel_x} + 9'd7) >= {1'b0, wx_ff});
      win_col  = req_data.pixel_x + 8'd7 - wx_ff;
      if (use_win) begin
         row     = win_line_ff;
         col     = win_col;
         map_idx = {lcdc_ff[LCDC_WIN_MAP], row[7:3], col[7:3]};
      end else begin
         row     = req_data.line + scy_ff;
         col     = req_data.pixel_x + scx_ff;
         map_idx = {lcdc_ff[LCDC_BG_MAP], row[7:3], col[7:3]};
      end
      s1_ctl_in.draw        = render && vis_px;
      s1_ctl_in.from_window = use_win;
      s1_ctl_in.row_lo      = row[2:0];
      s1_ctl_in.col_lo      = col[2:0];
   end

   always_comb begin
      win_active_in = win_active_ff;
      win_line_in   = win_line_ff;
      if (accept) begin
         if (req_data.op == OP_FRAME) begin
            win_active_in = 1'b0;
            win_line_in   = '0;
         end else if (render) begin
            win_active_in = act_now;
            if (req_data.line_end && win_on) begin
               win_line_in = win_line_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_active_ff <= 1'b0;
         win_line_ff   <= '0;
      end else begin
         win_active_ff <= win_active_in;
         win_line_ff   <= win_line_in;
      end
   end

   assign map_we  = accept && (req_data.op == OP_WRITE) && (req_data.mem_addr[12:11] == 2'b11);
   assign tile_we = accept && (req_data.op == OP_WRITE) && (req_data.mem_addr[12:11] != 2'b11);

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[req_data.mem_addr[10:0]] <= req_data.mem_data;
      end
      if (adv1) begin
         map_rd_ff <= map_mem[map_idx];
      end
   end

   assign tile_idx = {!lcdc_ff[LCDC_TILE_UNSGN] && !map_rd_ff[7], map_rd_ff, s1_ctl_ff.row_lo};

   always_ff @(posedge clock) begin
      if (tile_we) begin
         if (req_data.mem_addr[0]) begin
            tile_mem[req_data.mem_addr[12:1]][15:8] <= req_data.mem_data;
         end else begin
            tile_mem[req_data.mem_addr[12:1]][7:0] <= req_data.mem_data;
         end
      end
      if (adv2) begin
         tile_rd_ff <= tile_mem[tile_idx];
      end
   end

   always_comb begin
      bit_lo = 3'd7 - s2_ctl_ff.col_lo;
      cnum   = {tile_rd_ff[{1'b1, bit_lo}], tile_rd_ff[{1'b0, bit_lo}]};
      shade  = pal_ff[{cnum, 1'b0} +: 2];
      rsp_data_in = '0;
      if (s2_ctl_ff.draw) begin
         rsp_data_in.drawn       = 1'b1;
         rsp_data_in.shade       = shade;
         rsp_data_in.argb        = shade_argb(shade);
         rsp_data_in.from_window = s2_ctl_ff.from_window;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ctl_ff <= s1_ctl_in;
      end
      if (adv2) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
      if (adv3) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("Input not ready while the output stage is empty.");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_FRAME) |=> (win_line_ff == 8'd0 && !win_active_ff))
      else $error("Frame start did not clear the window state.");

   a_blank_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.drawn) |->
         (rsp_data_ff.shade == 2'd0 && rsp_data_ff.argb == 32'd0 && !rsp_data_ff.from_window))
      else $error("Undrawn result carries pixel data.");

   a_window_line_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(win_line_ff))
      else $error("Window line changed without an accepted item.");
`endif

endmodule
